### hdl/ovpm_pkg.sv
// Package of shared types and constants for the overlay pixel priority merge.
package ovpm_pkg;

    localparam int LINE_WIDTH_DEF = 256;

    localparam int COL_W   = 9;
    localparam int LAYER_W = 3;
    localparam int PRIO_W  = 4;
    localparam int COLOR_W = 16;
    localparam int RGB_W   = 15;
    localparam int EN_W    = 6;

    localparam logic [LAYER_W-1:0] OVL_MAX_LAYER = 3'd5;
    localparam logic [PRIO_W-1:0]  OVL_MAX_PRIO  = 4'd12;
    localparam int                 OPAQUE_BIT    = 15;

    typedef enum logic [1:0] {
        FN_LOAD    = 2'd0,
        FN_OVERLAY = 2'd1,
        FN_READ    = 2'd2,
        FN_NONE    = 2'd3
    } t_func;

    typedef enum logic {
        CFG_MAIN_EN = 1'b0,
        CFG_SUB_EN  = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        PLANE_MAIN = 1'b0,
        PLANE_SUB  = 1'b1
    } t_plane;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_MERGE = 1'b1
    } t_state;

    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [LAYER_W-1:0] layer;
        logic [RGB_W-1:0]   color;
        logic               exempt;
    } t_entry;

    typedef struct packed {
        logic [1:0]         func;
        logic [COL_W-1:0]   column;
        logic               plane;
        logic [LAYER_W-1:0] layer;
        logic [PRIO_W-1:0]  priority_req;
        logic [COLOR_W-1:0] color;
        logic               exempt;
        logic               main_masked;
        logic               sub_masked;
    } t_pixel;

    typedef struct packed {
        t_entry entry;
        logic   main_taken;
        logic   sub_taken;
    } t_result;

    // Controller to datapath.
    typedef struct packed {
        logic capture;
        logic commit;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

### hdl/ovpm_pix_if.sv
// Handshake channel that carries one input word of the overlay merge.
interface ovpm_pix_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [8:0]  column;
    logic        plane;
    logic [2:0]  layer;
    logic [3:0]  priority_req;
    logic [15:0] color;
    logic        exempt;
    logic        main_masked;
    logic        sub_masked;

    modport source (
        output valid, func, column, plane, layer, priority_req, color, exempt,
               main_masked, sub_masked,
        input  ready
    );
    modport sink (
        input  valid, func, column, plane, layer, priority_req, color, exempt,
               main_masked, sub_masked,
        output ready
    );
endinterface

### hdl/ovpm_res_if.sv
// Handshake channel that carries one result word of the overlay merge.
interface ovpm_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  entry_priority;
    logic [2:0]  entry_layer;
    logic [14:0] entry_color;
    logic        entry_exempt;
    logic        main_taken;
    logic        sub_taken;

    modport source (
        output valid, entry_priority, entry_layer, entry_color, entry_exempt,
               main_taken, sub_taken,
        input  ready
    );
    modport sink (
        input  valid, entry_priority, entry_layer, entry_color, entry_exempt,
               main_taken, sub_taken,
        output ready
    );
endinterface

### hdl/overlay_pixel_priority_merge.sv
// Top level of the overlay pixel priority merge over a two-plane scanline buffer.
// In the cycle an input word is accepted the column of both line memories is
// read into registers; then the priority compare runs and, once the output
// register is free, the winning entries are written back while the result
// word is loaded into the output register. The block takes no new input word
// until the current one has been written back. The output register lets the
// next input word be accepted while an earlier result still waits to be taken;
// when the output is stalled the write-back waits with it, so the line memories
// change only when the matching result word is produced. Every word yields
// exactly one result word: a read returns the stored entry (all zero for
// columns beyond the line), an overlay pixel reports in which planes it
// replaced the entry, and loads and the unused function return zero. Overlay
// pixels are dropped when the column lies beyond the line, the layer is above
// five, the priority is above twelve or the opaque bit is clear. Line memories
// have no reset; an entry must be loaded before it is read or merged into. The
// layer enable registers reset to zero and should be written only while the
// block is idle.
module overlay_pixel_priority_merge #(
    parameter int LINE_WIDTH = ovpm_pkg::LINE_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [ovpm_pkg::EN_W-1:0] i_cfg_data,
    ovpm_pix_if.sink                  i_pix,
    ovpm_res_if.source                o_res
);

    ovpm_pkg::t_pixel     pix;
    ovpm_pkg::t_dp_cmd    cmd;
    ovpm_pkg::t_dp_status status;
    ovpm_pkg::t_result    res;
    logic                 in_ready;
    logic                 out_valid;

    // Gather the input word into one packed bundle for the datapath.
    assign pix.func         = i_pix.func;
    assign pix.column       = i_pix.column;
    assign pix.plane        = i_pix.plane;
    assign pix.layer        = i_pix.layer;
    assign pix.priority_req = i_pix.priority_req;
    assign pix.color        = i_pix.color;
    assign pix.exempt       = i_pix.exempt;
    assign pix.main_masked  = i_pix.main_masked;
    assign pix.sub_masked   = i_pix.sub_masked;

    assign i_pix.ready = in_ready;

    ovpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ovpm_dp #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (pix),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (o_res.ready),
        .o_out_valid (out_valid),
        .o_out       (res)
    );

    // Spread the registered result word onto the output channel.
    assign o_res.valid          = out_valid;
    assign o_res.entry_priority = res.entry.prio;
    assign o_res.entry_layer    = res.entry.layer;
    assign o_res.entry_color    = res.entry.color;
    assign o_res.entry_exempt   = res.entry.exempt;
    assign o_res.main_taken     = res.main_taken;
    assign o_res.sub_taken      = res.sub_taken;

endmodule

### hdl/ovpm_ctrl.sv
// Controller state machine that sequences capture and write-back of each word.
module ovpm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ovpm_pkg::t_dp_status i_status,
    output ovpm_pkg::t_dp_cmd    o_cmd
);

    ovpm_pkg::t_state r_state;
    ovpm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ovpm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ovpm_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ovpm_pkg::ST_MERGE;
                end
            end
            ovpm_pkg::ST_MERGE: begin
                if (i_status.out_free) begin
                    n_state = ovpm_pkg::ST_IDLE;
                end
            end
            default: n_state = ovpm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.capture  = 1'b0;
        o_cmd.commit   = 1'b0;
        unique case (r_state)
            ovpm_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ovpm_pkg::ST_MERGE: begin
                o_cmd.commit = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

### hdl/ovpm_dp.sv
// Datapath: layer enables, line memories, priority compare and result register.
module ovpm_dp #(
    parameter int LINE_WIDTH = ovpm_pkg::LINE_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [ovpm_pkg::EN_W-1:0]  i_cfg_data,
    input  ovpm_pkg::t_pixel           i_pix,
    input  ovpm_pkg::t_dp_cmd          i_cmd,
    output ovpm_pkg::t_dp_status       o_status,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output ovpm_pkg::t_result          o_out
);

    localparam int AW = $clog2(LINE_WIDTH);

    logic [ovpm_pkg::EN_W-1:0] r_main_en;
    logic [ovpm_pkg::EN_W-1:0] r_sub_en;

    ovpm_pkg::t_entry main_mem [LINE_WIDTH];
    ovpm_pkg::t_entry sub_mem  [LINE_WIDTH];

    ovpm_pkg::t_pixel r_pix;
    logic             r_col_ok;
    logic [AW-1:0]    r_addr;
    ovpm_pkg::t_entry r_rd_main;
    ovpm_pkg::t_entry r_rd_sub;

    logic              r_out_valid;
    ovpm_pkg::t_result r_out;

    logic             in_col_ok;
    logic [AW-1:0]    in_addr;
    logic [7:0]       main_en8;
    logic [7:0]       sub_en8;
    logic             ovl_ok;
    logic             is_load;
    logic             is_ovl;
    logic             is_read;
    logic             main_take;
    logic             sub_take;
    logic             main_we;
    logic             sub_we;
    ovpm_pkg::t_entry new_entry;
    ovpm_pkg::t_result n_out;

    assign in_col_ok = (32'(i_pix.column) < LINE_WIDTH);
    assign in_addr   = AW'(i_pix.column);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_en <= '0;
            r_sub_en  <= '0;
        end else if (i_cfg_we) begin
            unique case (ovpm_pkg::t_cfg_idx'(i_cfg_idx))
                ovpm_pkg::CFG_MAIN_EN: r_main_en <= i_cfg_data;
                ovpm_pkg::CFG_SUB_EN:  r_sub_en  <= i_cfg_data;
                default:               r_main_en <= r_main_en;
            endcase
        end
    end

    // Capture the word and read both planes at the same column.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pix     <= i_pix;
            r_col_ok  <= in_col_ok;
            r_addr    <= in_addr;
            r_rd_main <= main_mem[in_addr];
            r_rd_sub  <= sub_mem[in_addr];
        end
    end

    assign main_en8 = 8'(r_main_en);
    assign sub_en8  = 8'(r_sub_en);

    assign is_load = (ovpm_pkg::t_func'(r_pix.func) == ovpm_pkg::FN_LOAD);
    assign is_ovl  = (ovpm_pkg::t_func'(r_pix.func) == ovpm_pkg::FN_OVERLAY);
    assign is_read = (ovpm_pkg::t_func'(r_pix.func) == ovpm_pkg::FN_READ);

    assign ovl_ok = is_ovl && r_col_ok
                 && (r_pix.layer <= ovpm_pkg::OVL_MAX_LAYER)
                 && (r_pix.priority_req <= ovpm_pkg::OVL_MAX_PRIO)
                 && r_pix.color[ovpm_pkg::OPAQUE_BIT];

    assign main_take = ovl_ok && main_en8[r_pix.layer] && !r_pix.main_masked
                    && (r_rd_main.prio < r_pix.priority_req);
    assign sub_take  = ovl_ok && sub_en8[r_pix.layer] && !r_pix.sub_masked
                    && (r_rd_sub.prio < r_pix.priority_req);

    assign new_entry.prio   = r_pix.priority_req;
    assign new_entry.layer  = r_pix.layer;
    assign new_entry.color  = r_pix.color[ovpm_pkg::RGB_W-1:0];
    assign new_entry.exempt = r_pix.exempt;

    assign main_we = i_cmd.commit && (main_take
                  || (is_load && r_col_ok && (r_pix.plane == ovpm_pkg::PLANE_MAIN)));
    assign sub_we  = i_cmd.commit && (sub_take
                  || (is_load && r_col_ok && (r_pix.plane == ovpm_pkg::PLANE_SUB)));

    always_ff @(posedge i_clk) begin
        if (main_we) begin
            main_mem[r_addr] <= new_entry;
        end
        if (sub_we) begin
            sub_mem[r_addr] <= new_entry;
        end
    end

    always_comb begin
        n_out            = '0;
        n_out.main_taken = main_take;
        n_out.sub_taken  = sub_take;
        if (is_read && r_col_ok) begin
            n_out.entry = (r_pix.plane == ovpm_pkg::PLANE_SUB) ? r_rd_sub : r_rd_main;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench of the overlay pixel priority merge: a directed table, then random words.
module tb;
    import ovpm_pkg::*;

    // The line is built at its default width; columns at or beyond it are off the line.
    localparam int LINE       = LINE_WIDTH_DEF;
    localparam int SOAK_WORDS = 750;
    localparam int SOAK_PHASE = SOAK_WORDS / 6;
    localparam int IDLE_PCT   = 12;

    // How a row of the directed table is treated: checked against the predictor,
    // checked against the result typed into the row, or a change of layer enables.
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_FIXED,
        ROW_ENABLES
    } t_row_kind;

    typedef struct {
        t_row_kind       kind;
        t_pixel          word;
        t_result         want;
        logic [EN_W-1:0] en_main;
        logic [EN_W-1:0] en_sub;
    } t_row;

    localparam t_result ZERO_RES = '0;

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            cfg_we;
    t_cfg_idx        cfg_idx;
    logic [EN_W-1:0] cfg_data;

    ovpm_pix_if pix ();
    ovpm_res_if res ();

    overlay_pixel_priority_merge dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix),
        .o_res      (res)
    );

    always #5 i_clk = ~i_clk;

    // The bench's own copy of both line planes and of the layer enables. The
    // loaded flags record which entries hold defined data: the line memories
    // have no reset, so no word is ever sent that would read or merge into an
    // entry that has not been loaded first.
    t_entry          main_line [LINE];
    t_entry          sub_line [LINE];
    bit              main_loaded [LINE];
    bit              sub_loaded [LINE];
    logic [EN_W-1:0] main_en;
    logic [EN_W-1:0] sub_en;

    // Result words still to come, oldest first.
    t_result         awaited_words [$];
    t_row            dir_rows [$];
    int              fail_count = 0;
    // While calm is set neither side idles, giving a long stretch at full rate.
    bit              calm = 1'b0;
    int              last_col = 0;

    // Works out the result word of one accepted input word and applies the
    // word to the bench's copy of the line planes.
    function automatic t_result predict_merge(input t_pixel w);
        t_result    r;
        t_entry     px;
        logic [7:0] at;
        logic       on_line;
        logic       fits;
        r          = '0;
        at         = w.column[7:0];
        on_line    = (w.column < LINE);
        px.prio    = w.priority_req;
        px.layer   = w.layer;
        px.color   = w.color[RGB_W-1:0];
        px.exempt  = w.exempt;
        case (t_func'(w.func))
            FN_LOAD: begin
                // The opaque bit is simply dropped on a load.
                if (on_line) begin
                    if (w.plane == PLANE_SUB)
                        sub_line[at] = px;
                    else
                        main_line[at] = px;
                end
            end
            FN_OVERLAY: begin
                fits = on_line && (w.layer <= OVL_MAX_LAYER)
                    && (w.priority_req <= OVL_MAX_PRIO) && w.color[OPAQUE_BIT];
                // A stored entry only gives way to a strictly higher priority.
                if (fits && main_en[w.layer] && !w.main_masked
                        && (main_line[at].prio < px.prio)) begin
                    main_line[at] = px;
                    r.main_taken  = 1'b1;
                end
                if (fits && sub_en[w.layer] && !w.sub_masked
                        && (sub_line[at].prio < px.prio)) begin
                    sub_line[at] = px;
                    r.sub_taken  = 1'b1;
                end
            end
            FN_READ: begin
                if (on_line)
                    r.entry = (w.plane == PLANE_SUB) ? sub_line[at] : main_line[at];
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_result entry_result(input int pr, input int lay, input int colr,
                                             input int ex);
        t_result r;
        r              = '0;
        r.entry.prio   = PRIO_W'(pr);
        r.entry.layer  = LAYER_W'(lay);
        r.entry.color  = RGB_W'(colr);
        r.entry.exempt = 1'(ex);
        return r;
    endfunction

    task automatic add_row(input t_row_kind kind, input t_func f, input int col,
                           input t_plane pl, input int lay, input int pr, input int colr,
                           input int ex, input int mm, input int sm, input t_result want);
        t_row row;
        row.kind              = kind;
        row.word.func         = f;
        row.word.column       = COL_W'(col);
        row.word.plane        = pl;
        row.word.layer        = LAYER_W'(lay);
        row.word.priority_req = PRIO_W'(pr);
        row.word.color        = COLOR_W'(colr);
        row.word.exempt       = 1'(ex);
        row.word.main_masked  = 1'(mm);
        row.word.sub_masked   = 1'(sm);
        row.want              = want;
        row.en_main           = '0;
        row.en_sub            = '0;
        dir_rows.push_back(row);
    endtask

    task automatic add_enables(input logic [EN_W-1:0] m, input logic [EN_W-1:0] s);
        t_row row;
        row.kind    = ROW_ENABLES;
        row.word    = '0;
        row.want    = '0;
        row.en_main = m;
        row.en_sub  = s;
        dir_rows.push_back(row);
    endtask

    // A load of random content into one entry.
    function automatic t_pixel load_word(input logic [7:0] at, input t_plane pl);
        t_pixel w;
        w.func         = FN_LOAD;
        w.column       = {1'b0, at};
        w.plane        = pl;
        w.layer        = LAYER_W'($urandom_range(7));
        w.priority_req = PRIO_W'($urandom_range(15));
        w.color        = COLOR_W'($urandom);
        w.exempt       = 1'($urandom_range(1));
        w.main_masked  = 1'($urandom_range(1));
        w.sub_masked   = 1'($urandom_range(1));
        return w;
    endfunction

    // One random word. Columns mostly stay in a narrow band, and often repeat
    // the previous one, so that back-to-back words hit the same entry and the
    // write-back just ahead of the next read is worked hard. Most words are
    // well-formed overlay pixels; the rest are loads, reads, unconstrained
    // overlays and the unused function.
    function automatic t_pixel soak_word();
        t_pixel w;
        int     pick;
        int     col;
        pick = $urandom_range(99);
        if (pick < 30)
            col = last_col;
        else if (pick < 70)
            col = $urandom_range(15);
        else if (pick < 85)
            col = $urandom_range(LINE - 1);
        else if (pick < 90)
            col = LINE - 1;
        else
            col = $urandom_range(511, LINE);
        last_col = col;

        w.func         = FN_OVERLAY;
        w.column       = COL_W'(col);
        w.plane        = 1'($urandom_range(1));
        w.layer        = LAYER_W'($urandom_range(OVL_MAX_LAYER));
        w.priority_req = PRIO_W'($urandom_range(OVL_MAX_PRIO));
        w.color        = {1'b1, RGB_W'($urandom)};
        w.exempt       = 1'($urandom_range(1));
        w.main_masked  = ($urandom_range(3) == 0);
        w.sub_masked   = ($urandom_range(3) == 0);

        pick = $urandom_range(99);
        if (pick < 20) begin
            w.func         = FN_LOAD;
            w.layer        = LAYER_W'($urandom_range(7));
            w.priority_req = PRIO_W'($urandom_range(15));
            w.color        = COLOR_W'($urandom);
        end else if (pick < 32) begin
            w.func = FN_READ;
        end else if (pick >= 85 && pick < 95) begin
            // Anything goes: many of these are dropped by the overlay limits.
            w.layer        = LAYER_W'($urandom_range(7));
            w.priority_req = PRIO_W'($urandom_range(15));
            w.color        = COLOR_W'($urandom);
            w.main_masked  = 1'($urandom_range(1));
            w.sub_masked   = 1'($urandom_range(1));
        end else if (pick >= 95) begin
            w.func  = FN_NONE;
            w.color = COLOR_W'($urandom);
        end
        return w;
    endfunction

    // Presents one word to the block, with a random gap ahead of it, and holds
    // it until it is accepted. The task returns in the time step of the edge
    // that took the word, leaving valid high so that the next word can follow
    // without a bubble.
    task automatic push_word(input t_pixel w, input t_row_kind kind, input t_result want);
        t_result guess;
        while (!calm && ($urandom_range(99) < IDLE_PCT)) begin
            pix.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix.valid        <= 1'b1;
        pix.func         <= w.func;
        pix.column       <= w.column;
        pix.plane        <= w.plane;
        pix.layer        <= w.layer;
        pix.priority_req <= w.priority_req;
        pix.color        <= w.color;
        pix.exempt       <= w.exempt;
        pix.main_masked  <= w.main_masked;
        pix.sub_masked   <= w.sub_masked;
        @(posedge i_clk);
        while (!pix.ready)
            @(posedge i_clk);
        // The predictor always runs so that its copy of the planes keeps up,
        // even where the row carries its own typed result.
        guess = predict_merge(w);
        awaited_words.push_back((kind == ROW_FIXED) ? want : guess);
        if (t_func'(w.func) == FN_LOAD && w.column < LINE) begin
            if (w.plane == PLANE_SUB)
                sub_loaded[w.column[7:0]] = 1'b1;
            else
                main_loaded[w.column[7:0]] = 1'b1;
        end
    endtask

    // Sends a word, but first loads any entry that the word would read or
    // merge into while it is still undefined.
    task automatic issue_word(input t_pixel w, input t_row_kind kind, input t_result want);
        logic [7:0] at;
        logic       fits;
        logic       is_read;
        at      = w.column[7:0];
        is_read = (t_func'(w.func) == FN_READ);
        fits    = (t_func'(w.func) == FN_OVERLAY) && (w.layer <= OVL_MAX_LAYER)
            && (w.priority_req <= OVL_MAX_PRIO) && w.color[OPAQUE_BIT];
        if (w.column < LINE) begin
            if (!main_loaded[at] && ((is_read && w.plane == PLANE_MAIN)
                    || (fits && main_en[w.layer] && !w.main_masked)))
                push_word(load_word(at, PLANE_MAIN), ROW_PREDICT, ZERO_RES);
            if (!sub_loaded[at] && ((is_read && w.plane == PLANE_SUB)
                    || (fits && sub_en[w.layer] && !w.sub_masked)))
                push_word(load_word(at, PLANE_SUB), ROW_PREDICT, ZERO_RES);
        end
        push_word(w, kind, want);
    endtask

    // Holds the sender off until every awaited result word has been taken.
    task automatic drain_results();
        pix.valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_words.size() != 0)
            @(posedge i_clk);
    endtask

    // Writes both layer enable registers while the block is idle. The short
    // pause after the drain covers the read and write-back stages.
    task automatic set_enables(input logic [EN_W-1:0] m, input logic [EN_W-1:0] s);
        drain_results();
        repeat (2) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_MAIN_EN;
        cfg_data <= m;
        @(posedge i_clk);
        cfg_idx  <= CFG_SUB_EN;
        cfg_data <= s;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        main_en  = m;
        sub_en   = s;
    endtask

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    // Compares the result word on the bus with the oldest awaited one.
    task automatic check_result();
        t_result want;
        if (awaited_words.size() == 0) begin
            report_mismatch("result word arrived with nothing awaited");
            return;
        end
        want = awaited_words.pop_front();
        if (res.entry_priority !== want.entry.prio)
            report_mismatch($sformatf("entry_priority %0d, expected %0d",
                res.entry_priority, want.entry.prio));
        if (res.entry_layer !== want.entry.layer)
            report_mismatch($sformatf("entry_layer %0d, expected %0d",
                res.entry_layer, want.entry.layer));
        if (res.entry_color !== want.entry.color)
            report_mismatch($sformatf("entry_color %h, expected %h",
                res.entry_color, want.entry.color));
        if (res.entry_exempt !== want.entry.exempt)
            report_mismatch($sformatf("entry_exempt %b, expected %b",
                res.entry_exempt, want.entry.exempt));
        if (res.main_taken !== want.main_taken)
            report_mismatch($sformatf("main_taken %b, expected %b",
                res.main_taken, want.main_taken));
        if (res.sub_taken !== want.sub_taken)
            report_mismatch($sformatf("sub_taken %b, expected %b",
                res.sub_taken, want.sub_taken));
    endtask

    // Result side: values are sampled as they stood at the edge, and ready is
    // then driven for the next cycle, idling now and then unless calm is set.
    initial begin
        res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res.valid && res.ready)
                check_result();
            res.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Directed table. Rows marked ROW_FIXED carry the result that is plain to
    // see: zeros after reset, dropped pixels, and reads of freshly loaded
    // entries. The others are left to the predictor.
    initial begin
        // Enables still at reset: no overlay pixel can land on either plane. The
        // opaque bit of a load is dropped, the unused function does nothing, and
        // columns beyond the line are ignored or read back as zero.
        add_row(ROW_FIXED,   FN_LOAD,    0,   PLANE_MAIN, 2, 5,  'hFFFF, 1, 0, 0, ZERO_RES);
        add_row(ROW_FIXED,   FN_LOAD,    0,   PLANE_SUB,  0, 0,  'h0000, 0, 0, 0, ZERO_RES);
        add_row(ROW_FIXED,   FN_READ,    0,   PLANE_MAIN, 0, 0,  'h0000, 0, 0, 0,
                entry_result(5, 2, 'h7FFF, 1));
        add_row(ROW_FIXED,   FN_READ,    0,   PLANE_SUB,  0, 0,  'h0000, 0, 0, 0, ZERO_RES);
        add_row(ROW_FIXED,   FN_OVERLAY, 0,   PLANE_MAIN, 0, 12, 'h8001, 0, 0, 0, ZERO_RES);
        add_row(ROW_FIXED,   FN_NONE,    0,   PLANE_SUB,  7, 15, 'hFFFF, 1, 1, 1, ZERO_RES);
        add_row(ROW_FIXED,   FN_LOAD,    511, PLANE_MAIN, 7, 15, 'hFFFF, 1, 1, 1, ZERO_RES);
        add_row(ROW_FIXED,   FN_READ,    256, PLANE_SUB,  7, 15, 'hFFFF, 1, 1, 1, ZERO_RES);
        // Every layer enabled on both planes.
        add_enables(EN_W'('h3F), EN_W'('h3F));
        add_row(ROW_PREDICT, FN_OVERLAY, 0,   PLANE_MAIN, 0, 12, 'h8123, 0, 0, 0, ZERO_RES);
        add_row(ROW_PREDICT, FN_READ,    0,   PLANE_MAIN, 0, 0,  'h0000, 0, 0, 0, ZERO_RES);
        // Equal priority does not replace the entry.
        add_row(ROW_PREDICT, FN_OVERLAY, 0,   PLANE_MAIN, 0, 12, 'hFFFF, 1, 0, 0, ZERO_RES);
        // Dropped pixels: layer too high, priority too high, transparent,
        // and a column beyond the line.
        add_row(ROW_FIXED,   FN_OVERLAY, 0,   PLANE_MAIN, 6, 12, 'hFFFF, 1, 0, 0, ZERO_RES);
        add_row(ROW_FIXED,   FN_OVERLAY, 0,   PLANE_MAIN, 5, 13, 'hFFFF, 1, 0, 0, ZERO_RES);
        add_row(ROW_FIXED,   FN_OVERLAY, 0,   PLANE_MAIN, 0, 12, 'h7FFF, 1, 0, 0, ZERO_RES);
        add_row(ROW_FIXED,   FN_OVERLAY, 300, PLANE_MAIN, 0, 12, 'hFFFF, 1, 0, 0, ZERO_RES);
        // Loaded layer and priority are kept as given, even past the overlay limits.
        add_row(ROW_FIXED,   FN_LOAD,    255, PLANE_MAIN, 7, 15, 'h7FFF, 1, 0, 0, ZERO_RES);
        add_row(ROW_FIXED,   FN_LOAD,    255, PLANE_SUB,  7, 3,  'h0000, 0, 0, 0, ZERO_RES);
        add_row(ROW_FIXED,   FN_READ,    255, PLANE_MAIN, 0, 0,  'h0000, 0, 0, 0,
                entry_result(15, 7, 'h7FFF, 1));
        // Window masks, one plane at a time.
        add_row(ROW_PREDICT, FN_OVERLAY, 255, PLANE_MAIN, 5, 12, 'hFFFF, 1, 1, 0, ZERO_RES);
        add_row(ROW_PREDICT, FN_OVERLAY, 255, PLANE_MAIN, 5, 12, 'h8000, 0, 0, 1, ZERO_RES);
        add_row(ROW_PREDICT, FN_READ,    255, PLANE_SUB,  0, 0,  'h0000, 0, 0, 0, ZERO_RES);
        // Only layer five may reach the sub plane, and nothing the main plane.
        add_enables(EN_W'('h00), EN_W'('h20));
        add_row(ROW_FIXED,   FN_LOAD,    1,   PLANE_MAIN, 0, 0,  'h0000, 0, 0, 0, ZERO_RES);
        add_row(ROW_FIXED,   FN_LOAD,    1,   PLANE_SUB,  0, 0,  'h0000, 0, 0, 0, ZERO_RES);
        add_row(ROW_PREDICT, FN_OVERLAY, 1,   PLANE_MAIN, 4, 1,  'h8ABC, 1, 0, 0, ZERO_RES);
        add_row(ROW_PREDICT, FN_OVERLAY, 1,   PLANE_MAIN, 5, 1,  'hD555, 0, 0, 0, ZERO_RES);
    end

    // Stimulus: reset, the directed table, then random words in phases of
    // layer enables. Each phase change drains the block first, so the sender
    // is held off until every awaited result word has come.
    initial begin
        i_rst_n          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= CFG_MAIN_EN;
        cfg_data         <= '0;
        pix.valid        <= 1'b0;
        pix.func         <= FN_LOAD;
        pix.column       <= '0;
        pix.plane        <= PLANE_MAIN;
        pix.layer        <= '0;
        pix.priority_req <= '0;
        pix.color        <= '0;
        pix.exempt       <= 1'b0;
        pix.main_masked  <= 1'b0;
        pix.sub_masked   <= 1'b0;
        main_en          = '0;
        sub_en           = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_ENABLES)
                set_enables(dir_rows[i].en_main, dir_rows[i].en_sub);
            else
                issue_word(dir_rows[i].word, dir_rows[i].kind, dir_rows[i].want);
        end

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_enables(EN_W'('h3F), EN_W'('h3F));
                1: set_enables(EN_W'('h00), EN_W'('h3F));
                2: set_enables(EN_W'('h3F), EN_W'('h00));
                5: set_enables(EN_W'('h15), EN_W'('h2A));
                default: set_enables(EN_W'($urandom), EN_W'($urandom));
            endcase
            // One whole phase runs with neither side idling.
            calm = (phase == 3);
            for (int n = 0; n < SOAK_PHASE; n++)
                issue_word(soak_word(), ROW_PREDICT, ZERO_RES);
        end
        calm = 1'b0;

        drain_results();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // This bound lies far beyond the length of a correct run.
    initial begin
        #1000000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

### filelist.f
hdl/ovpm_pkg.sv
hdl/ovpm_pix_if.sv
hdl/ovpm_res_if.sv
hdl/ovpm_ctrl.sv
hdl/ovpm_dp.sv
hdl/overlay_pixel_priority_merge.sv
bench/tb.sv
